// ===== design/lz77pd_pkg.sv =====
// Package for the LZ77 page decompressor.
// Holds the parse phase type, status codes, opcode constants and sizes.
// No dependencies.
package lz77pd_pkg;

  localparam int HIST_BYTES = 32768;
  localparam int HIST_AW    = $clog2(HIST_BYTES);
  localparam int COUNT_BITS = 32;
  localparam int DIST_W     = 16;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_PUSH = 2'd0;
  localparam cmd_t CMD_TICK = 2'd1;
  localparam cmd_t CMD_PAGE = 2'd2;
  localparam cmd_t CMD_NOP  = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK     = 3'd0;
  localparam status_t ST_END    = 3'd1;
  localparam status_t ST_BADOP  = 3'd2;
  localparam status_t ST_BADOFF = 3'd3;
  localparam status_t ST_BUSY   = 3'd4;
  localparam status_t ST_AFTER  = 3'd5;

  localparam logic [7:0] OP_END     = 8'h11;
  localparam logic [7:0] OP_NEAR_LO = 8'h12;
  localparam logic [7:0] OP_LONG20  = 8'h20;
  localparam logic [7:0] OP_LONG10  = 8'h10;
  localparam logic [7:0] OP_MID_LO  = 8'h21;
  localparam logic [7:0] OP_SHORT   = 8'h40;
  localparam logic [7:0] OP_MID_SUB = 8'h1E;
  localparam logic [7:0] EXT_STEP   = 8'hFF;
  localparam logic [7:0] NIB_MASK   = 8'h0F;
  localparam logic [14:0] FAR_BIAS  = 15'h3FFF;

  typedef enum logic [3:0] {
    PH_LEAD, PH_LITEXT, PH_LIT, PH_OPCODE, PH_LENFIRST,
    PH_LENEXT, PH_OFFA, PH_OFFB, PH_OPNEW, PH_DONE
  } phase_t;

endpackage

// ===== design/lz77_page_decompressor.sv =====
// LZ77 page decompressor top level: parser, history memory and output stage.
// Depends on lz77pd_pkg.
//
// One command per input transaction (push byte, tick, new page), one result
// transaction per command, in order. Rate: one transaction per cycle,
// back to back unless the output stalls; valid the cycle after accept. The
// parser state updates in the accept cycle and issues the history read; the
// second stage registers the read data and holds the result. The byte a tick
// copies is written back to history as its result leaves the output stage;
// a read of that same entry in the same cycle is forwarded, so a match at
// distance one still runs at full rate. A stalled output stalls the input.
// History is 32 KiB, undefined until written; no clearing pass.
module lz77_page_decompressor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [1:0] cmd, [9:2] in_byte, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [0] out_valid, [8:1] out_byte,
                                     // [9] copy_pending, [12:10] status
);
  import lz77pd_pkg::*;

  // parser state
  phase_t                phase, phase_next;
  logic [7:0]            held, held_next;
  logic [COUNT_BITS-1:0] lit_rem, lit_rem_next;
  logic [COUNT_BITS-1:0] match_rem, match_rem_next;
  logic [DIST_W-1:0]     match_dist, match_dist_next;
  logic [COUNT_BITS-1:0] acc, acc_next;
  logic [7:0]            first_off, first_off_next;
  logic [HIST_AW-1:0]    wp, wp_next;
  logic [COUNT_BITS-1:0] bw, bw_next;
  status_t               sticky, sticky_next;

  // history memory
  logic [7:0]         hist [HIST_BYTES];
  logic [7:0]         rdata;
  logic [HIST_AW-1:0] raddr;

  // output stage
  logic               s2_valid;
  logic               s2_emit;     // result carries a byte
  logic               s2_mem;      // byte comes from history
  logic               s2_fwd;
  logic [7:0]         s2_fwd_byte;
  logic [7:0]         s2_lit;
  logic               s2_pend;
  status_t            s2_status;
  logic [HIST_AW-1:0] s2_waddr;
  logic [7:0]         s2_byte;

  cmd_t       cmd;
  logic [7:0] b;
  logic       in_acc, out_acc;
  logic       emit, from_mem;
  status_t    st;
  logic       fwd_now;

  logic [COUNT_BITS:0]   sum;
  logic [7:0]            base;
  logic [14:0]           off;
  logic [DIST_W-1:0]     mdist;
  logic [COUNT_BITS-1:0] mlen;
  logic [1:0]            mlit;
  logic                  do_match;

  assign cmd     = s_axis_tdata[1:0];
  assign b       = s_axis_tdata[9:2];
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !s2_valid || m_axis_tready;
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign raddr = wp - match_dist[HIST_AW-1:0];
  assign s2_byte = s2_fwd ? s2_fwd_byte : (s2_mem ? rdata : s2_lit);
  // previous item's byte is written at this same edge
  assign fwd_now = s2_valid && s2_emit && (s2_waddr == raddr);

  always_comb begin
    phase_next      = phase;
    held_next       = held;
    lit_rem_next    = lit_rem;
    match_rem_next  = match_rem;
    match_dist_next = match_dist;
    acc_next        = acc;
    first_off_next  = first_off;
    wp_next         = wp;
    bw_next         = bw;
    sticky_next     = sticky;
    emit     = 1'b0;
    from_mem = 1'b0;
    st       = sticky;
    sum      = '0;
    base     = (held == OP_LONG20) ? OP_MID_LO : 8'd9;
    off      = '0;
    mdist    = '0;
    mlen     = '0;
    mlit     = '0;
    do_match = 1'b0;

    case (cmd)
      CMD_PUSH: begin
        if (phase != PH_DONE && match_rem != '0) begin
          st = ST_BUSY;
        end else begin
          st = ST_OK;
          case (phase)
            PH_LEAD, PH_OPCODE: begin
              if (phase == PH_LEAD && b == 8'd0) begin
                acc_next   = {{(COUNT_BITS-8){1'b0}}, NIB_MASK};
                phase_next = PH_LITEXT;
              end else if (phase == PH_LEAD && b[7:4] == 4'd0) begin
                lit_rem_next = COUNT_BITS'(b) + COUNT_BITS'(3);
                held_next    = '0;
                phase_next   = PH_LIT;
              end else begin
                held_next = b;
                if (b == OP_END) begin
                  sticky_next = ST_END;
                  phase_next  = PH_DONE;
                  st          = ST_END;
                end else if (b >= OP_SHORT) begin
                  phase_next = PH_OPNEW;
                end else if (b >= OP_MID_LO) begin
                  acc_next   = COUNT_BITS'(b - OP_MID_SUB);
                  phase_next = PH_OFFA;
                end else if (b == OP_LONG20 || b == OP_LONG10) begin
                  phase_next = PH_LENFIRST;
                end else if (b >= OP_NEAR_LO) begin
                  acc_next   = COUNT_BITS'((b & NIB_MASK) + 8'd2);
                  phase_next = PH_OFFA;
                end else begin
                  sticky_next    = ST_BADOP;
                  phase_next     = PH_DONE;
                  match_rem_next = '0;
                  lit_rem_next   = '0;
                  st             = ST_BADOP;
                end
              end
            end
            PH_LITEXT: begin
              if (b == 8'd0) begin
                sum      = {1'b0, acc} + (COUNT_BITS+1)'(EXT_STEP);
                acc_next = sum[COUNT_BITS] ? CNT_MAX : sum[COUNT_BITS-1:0];
              end else begin
                sum = {1'b0, acc} + (COUNT_BITS+1)'(b) + (COUNT_BITS+1)'(3);
                lit_rem_next = sum[COUNT_BITS] ? CNT_MAX : sum[COUNT_BITS-1:0];
                held_next  = '0;
                phase_next = PH_LIT;
              end
            end
            PH_LIT: begin
              emit = 1'b1;
              if (lit_rem > COUNT_BITS'(1)) begin
                lit_rem_next = lit_rem - COUNT_BITS'(1);
              end else begin
                lit_rem_next = '0;
                phase_next   = PH_OPCODE;
              end
            end
            PH_LENFIRST: begin
              if (b == 8'd0) begin
                acc_next   = COUNT_BITS'(EXT_STEP);
                phase_next = PH_LENEXT;
              end else begin
                acc_next   = COUNT_BITS'(b) + COUNT_BITS'(base);
                phase_next = PH_OFFA;
              end
            end
            PH_LENEXT: begin
              if (b == 8'd0) begin
                sum = {1'b0, acc} + (COUNT_BITS+1)'(EXT_STEP);
              end else begin
                sum = {1'b0, acc} + (COUNT_BITS+1)'(b) + (COUNT_BITS+1)'(base);
                phase_next = PH_OFFA;
              end
              acc_next = sum[COUNT_BITS] ? CNT_MAX : sum[COUNT_BITS-1:0];
            end
            PH_OFFA: begin
              first_off_next = b;
              phase_next     = PH_OFFB;
            end
            PH_OFFB: begin
              off = {1'b0, b, first_off[7:2]};
              if (held < OP_LONG20) off = off + FAR_BIAS;
              mdist    = DIST_W'(off) + DIST_W'(1);
              mlen     = acc;
              mlit     = first_off[1:0];
              do_match = 1'b1;
            end
            PH_OPNEW: begin
              mdist    = DIST_W'({b, held[3:2]}) + DIST_W'(1);
              mlen     = COUNT_BITS'(held[7:4] - 4'd1);
              mlit     = held[1:0];
              do_match = 1'b1;
            end
            default: begin
              st = (sticky == ST_END) ? ST_AFTER : sticky;
            end
          endcase
          if (do_match) begin
            if (COUNT_BITS'(mdist) > bw) begin
              sticky_next    = ST_BADOFF;
              phase_next     = PH_DONE;
              match_rem_next = '0;
              lit_rem_next   = '0;
              st             = ST_BADOFF;
            end else begin
              match_rem_next  = mlen;
              match_dist_next = mdist;
              held_next       = '0;
              if (mlit != 2'd0) begin
                lit_rem_next = COUNT_BITS'(mlit);
                phase_next   = PH_LIT;
              end else begin
                phase_next = PH_LEAD;
              end
            end
          end
        end
      end
      CMD_TICK: begin
        if (match_rem != '0) begin
          emit           = 1'b1;
          from_mem       = 1'b1;
          match_rem_next = match_rem - COUNT_BITS'(1);
        end
      end
      CMD_PAGE: begin
        phase_next      = PH_LEAD;
        held_next       = '0;
        lit_rem_next    = '0;
        match_rem_next  = '0;
        match_dist_next = '0;
        acc_next        = '0;
        first_off_next  = '0;
        sticky_next     = ST_OK;
        st              = ST_OK;
      end
      default: ;
    endcase

    if (emit) begin
      wp_next = wp + HIST_AW'(1);
      bw_next = (bw == CNT_MAX) ? bw : bw + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      held       <= '0;
      lit_rem    <= '0;
      match_rem  <= '0;
      match_dist <= '0;
      acc        <= '0;
      first_off  <= '0;
      wp         <= '0;
      bw         <= '0;
      sticky     <= ST_OK;
      s2_valid   <= 1'b0;
    end else begin
      if (in_acc) begin
        phase      <= phase_next;
        held       <= held_next;
        lit_rem    <= lit_rem_next;
        match_rem  <= match_rem_next;
        match_dist <= match_dist_next;
        acc        <= acc_next;
        first_off  <= first_off_next;
        wp         <= wp_next;
        bw         <= bw_next;
        sticky     <= sticky_next;
        s2_valid   <= 1'b1;
      end else if (out_acc) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_emit     <= emit;
      s2_mem      <= from_mem;
      s2_fwd      <= fwd_now && from_mem;
      s2_fwd_byte <= s2_byte;
      s2_lit      <= (emit && !from_mem) ? b : 8'd0;
      s2_pend     <= (match_rem_next != '0);
      s2_status   <= st;
      s2_waddr    <= wp;
    end
  end

  // history: one read, one write per cycle
  always_ff @(posedge clk) begin
    if (in_acc) rdata <= hist[raddr];
    if (out_acc && s2_emit) hist[s2_waddr] <= s2_byte;
  end

  assign m_axis_tvalid = s2_valid;
  assign m_axis_tdata  = {3'd0, s2_status, s2_pend, s2_byte, s2_emit};

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> m_axis_tvalid) else $error("result missing after accept");

  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && emit |=> wp == $past(wp) + HIST_AW'(1))
    else $error("write pointer did not advance on emitted byte");

  a_bw_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> bw >= $past(bw)) else $error("byte count went backward");

endmodule

// ===== test/tb_lz77_page_decompressor.sv =====
// Testbench for lz77_page_decompressor: directed table plus random page streams.
// Every result transaction is checked against a behavioral decompressor model.
// Depends on lz77pd_pkg and the design top level.
`timescale 1ns / 1ps

module tb_lz77_page_decompressor;
  import lz77pd_pkg::*;

  localparam int IDLE_MAX = 12;
  localparam int WDOG_LIMIT = 2000;

  // field order matches m_axis_tdata, out_valid in bit 0
  typedef struct packed {
    status_t    st;
    logic       pend;
    logic [7:0] data;
    logic       vld;
  } result_t;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] byt;
    logic       known;  // expected result typed in
    result_t    res;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  lz77_page_decompressor dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Decompressor model state
  phase_t      phase;
  logic [7:0]  op_held;
  logic [63:0] lit_left;
  logic [63:0] copy_left;
  logic [31:0] copy_dist;
  logic [63:0] len_acc;
  logic [7:0]  off_lo;
  logic [7:0]  hist [HIST_BYTES];
  logic [HIST_AW-1:0] wptr;
  logic [63:0] produced;
  status_t     sticky;

  result_t     expected_q[$];
  int          errors;
  int          n_out, n_copied, n_pages;
  int          wdog;
  logic        done_in;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] clamp(logic [63:0] v);
    return (v > {32'd0, CNT_MAX}) ? {32'd0, CNT_MAX} : v;
  endfunction

  task automatic model_reset();
    phase = PH_LEAD; op_held = '0; lit_left = '0; copy_left = '0; copy_dist = '0;
    len_acc = '0; off_lo = '0; wptr = '0; produced = '0; sticky = ST_OK;
  endtask

  task automatic hist_write(logic [7:0] b);
    hist[wptr] = b;
    wptr = wptr + 1'b1;
    produced = clamp(produced + 1);
  endtask

  task automatic halt(status_t code);
    sticky = code; phase = PH_DONE; copy_left = '0; lit_left = '0;
  endtask

  task automatic decode_op(logic [7:0] op, output status_t st);
    op_held = op;
    st = ST_OK;
    if (op == OP_END) begin
      sticky = ST_END; phase = PH_DONE; st = ST_END;
    end else if (op >= OP_SHORT) begin
      phase = PH_OPNEW;
    end else if (op >= OP_MID_LO) begin
      len_acc = op - OP_MID_SUB; phase = PH_OFFA;
    end else if (op == OP_LONG20 || op == OP_LONG10) begin
      phase = PH_LENFIRST;
    end else if (op >= OP_NEAR_LO) begin
      len_acc = (op & NIB_MASK) + 2; phase = PH_OFFA;
    end else begin
      halt(ST_BADOP); st = ST_BADOP;
    end
  endtask

  task automatic begin_copy(logic [63:0] len, logic [31:0] off, logic [1:0] lit,
                            output status_t st);
    logic [31:0] d;
    d = off + 1;
    st = ST_OK;
    if ({32'd0, d} > produced || d > HIST_BYTES) begin
      halt(ST_BADOFF); st = ST_BADOFF;
    end else begin
      copy_left = clamp(len); copy_dist = d; op_held = '0;
      if (lit != 0) begin
        lit_left = lit; phase = PH_LIT;
      end else phase = PH_LEAD;
    end
  endtask

  task automatic take_byte(logic [7:0] b, output status_t st, output logic vld);
    logic [31:0] base, off;
    base = (op_held == OP_LONG20) ? 32'h21 : 32'd9;
    vld = 1'b0;
    st = ST_OK;
    case (phase)
      PH_LEAD: begin
        if (b == 0) begin
          len_acc = NIB_MASK; phase = PH_LITEXT;
        end else if (b[7:4] != 0) decode_op(b, st);
        else begin
          lit_left = b + 3; op_held = '0; phase = PH_LIT;
        end
      end
      PH_LITEXT: begin
        if (b == 0) len_acc = clamp(len_acc + EXT_STEP);
        else begin
          lit_left = clamp(len_acc + b + 3); op_held = '0; phase = PH_LIT;
        end
      end
      PH_LIT: begin
        hist_write(b);
        vld = 1'b1;
        if (lit_left > 0) lit_left--;
        if (lit_left == 0) phase = PH_OPCODE;
      end
      PH_OPCODE: decode_op(b, st);
      PH_LENFIRST: begin
        if (b == 0) begin
          len_acc = EXT_STEP; phase = PH_LENEXT;
        end else begin
          len_acc = b + base; phase = PH_OFFA;
        end
      end
      PH_LENEXT: begin
        if (b == 0) len_acc = clamp(len_acc + EXT_STEP);
        else begin
          len_acc = clamp(len_acc + b + base); phase = PH_OFFA;
        end
      end
      PH_OFFA: begin
        off_lo = b; phase = PH_OFFB;
      end
      PH_OFFB: begin
        off = (off_lo >> 2) | (32'(b) << 6);
        if (op_held < OP_LONG20) off += FAR_BIAS;
        begin_copy(len_acc, off, off_lo[1:0], st);
      end
      PH_OPNEW: begin
        off = (32'(b) << 2) | ((op_held & 8'h0C) >> 2);
        begin_copy(32'(op_held[7:4]) - 1, off, op_held[1:0], st);
      end
      default: st = (sticky == ST_END) ? ST_AFTER : sticky;
    endcase
  endtask

  // Computes the expected result of one command and advances the model.
  task automatic decompress_step(cmd_t cmd, logic [7:0] b, output result_t r);
    status_t st;
    logic vld;
    logic [7:0] ob;
    logic [HIST_AW-1:0] idx;
    st = sticky; vld = 1'b0; ob = '0;
    if (cmd == CMD_PUSH) begin
      if (phase != PH_DONE && copy_left > 0) st = ST_BUSY;
      else begin
        take_byte(b, st, vld);
        if (vld) ob = b;
      end
    end else if (cmd == CMD_TICK) begin
      if (copy_left > 0) begin
        idx = wptr - copy_dist[HIST_AW-1:0];
        ob = hist[idx];
        hist_write(ob);
        vld = 1'b1;
        copy_left--;
        n_copied++;
      end
    end else if (cmd == CMD_PAGE) begin
      phase = PH_LEAD; op_held = '0; lit_left = '0; copy_left = '0; copy_dist = '0;
      len_acc = '0; off_lo = '0; sticky = ST_OK; st = ST_OK;
      n_pages++;
    end
    r.vld = vld; r.data = ob; r.pend = (copy_left > 0); r.st = st;
  endtask

  task automatic report(string what, result_t got, result_t exp);
    errors++;
    $display("mismatch %s at %0t: got v%0b %02h p%0b s%0d, exp v%0b %02h p%0b s%0d",
             what, $realtime, got.vld, got.data, got.pend, got.st,
             exp.vld, exp.data, exp.pend, exp.st);
  endtask

  // Sends one command: random gap, then hold valid until accepted.
  task automatic send(cmd_t cmd, logic [7:0] b, logic known, result_t res);
    result_t r;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, b, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decompress_step(cmd, b, r);
    if (known && r !== res) report("table", r, res);
    expected_q.push_back(r);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Result side: random stall per transaction, compare in order.
  initial begin
    int stall;
    result_t got;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, IDLE_MAX);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      got = result_t'(m_axis_tdata[12:0]);
      n_out++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("unexpected result transaction at %0t", $realtime);
      end else begin
        result_t e;
        e = expected_q.pop_front();
        if (got.vld !== e.vld) report("out_valid", got, e);
        else if (got.data !== e.data) report("out_byte", got, e);
        else if (got.pend !== e.pend) report("copy_pending", got, e);
        else if (got.st !== e.st) report("status", got, e);
      end
    end
  end

  // Watchdog: cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      wdog <= 0;
    else if (!done_in || expected_q.size() != 0) begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", expected_q.size());
        $display("** lz77_page_decompressor: FAILED **");
        $finish;
      end
    end
  end

  localparam result_t R0 = '0;

  function automatic result_t res(logic v, logic [7:0] d, logic p, status_t s);
    result_t r;
    r.vld = v; r.data = d; r.pend = p; r.st = s;
    return r;
  endfunction

  // Random page: literals, matches, noise bytes, and an end marker unless an error ended the page.
  task automatic random_page(ref int count);
    int nops, k, lits;
    logic [7:0] op;
    logic [31:0] dmax;
    send(CMD_PAGE, 8'($urandom), 0, R0); count++;
    lits = $urandom_range(1, 15) + 3;
    if ($urandom_range(0, 5) == 0) begin
      send(CMD_PUSH, 8'h00, 0, R0);
      send(CMD_PUSH, 8'($urandom_range(1, 255)), 0, R0);
      count += 2;
      lits = -1;
    end else begin
      send(CMD_PUSH, 8'(lits - 3), 0, R0); count++;
    end
    while (phase == PH_LIT) begin
      send(CMD_PUSH, 8'($urandom), 0, R0); count++;
      if (count > 60000) break;
    end
    nops = $urandom_range(1, 6);
    for (k = 0; k < nops && phase == PH_OPCODE || phase == PH_LEAD && k < nops; k++) begin
      dmax = (produced > 1024) ? 1024 : produced[31:0];
      case ($urandom_range(0, 3))
        0: begin  // short match
          op = 8'($urandom_range(4, 15) << 4) | 8'($urandom_range(0, 15));
          op[3:2] = 2'($urandom_range(0, 3));
          send(CMD_PUSH, op, 0, R0);
          send(CMD_PUSH, 8'($urandom_range(0, (dmax - 1) >> 2)), 0, R0);
        end
        1: begin  // mid match
          send(CMD_PUSH, 8'($urandom_range(8'h21, 8'h3F)), 0, R0);
          send(CMD_PUSH, 8'($urandom_range(0, 63) << 2 | $urandom_range(0, 3)), 0, R0);
          send(CMD_PUSH, 8'd0, 0, R0);
        end
        2: begin  // long match, optional extension
          send(CMD_PUSH, OP_LONG20, 0, R0);
          if ($urandom_range(0, 3) == 0) send(CMD_PUSH, 8'd0, 0, R0);
          send(CMD_PUSH, 8'($urandom_range(1, 40)), 0, R0);
          send(CMD_PUSH, 8'($urandom_range(0, 255)), 0, R0);
          send(CMD_PUSH, 8'($urandom_range(0, 3)), 0, R0);
        end
        default: begin  // noise
          send(CMD_PUSH, 8'($urandom), 0, R0);
        end
      endcase
      count += 3;
      while (copy_left > 0) begin
        if ($urandom_range(0, 15) == 0) send(CMD_PUSH, 8'($urandom), 0, R0);
        else send(CMD_TICK, 8'($urandom), 0, R0);
        count++;
      end
      while (phase == PH_LIT) begin
        send(CMD_PUSH, 8'($urandom), 0, R0); count++;
      end
      if (phase == PH_DONE) break;
    end
    if (phase != PH_DONE) begin
      send(CMD_PUSH, OP_END, 0, R0); count++;
    end
    if ($urandom_range(0, 2) == 0) begin
      send(CMD_PUSH, 8'($urandom), 0, R0);
      send(CMD_TICK, 8'($urandom), 0, R0);
      send(CMD_NOP, 8'($urandom), 0, R0);
      count += 3;
    end
  endtask

  initial begin
    row_t tbl[$];
    int count;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    errors = 0; n_out = 0; n_copied = 0; n_pages = 0;
    done_in = 1'b0;
    model_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset state, extremes, each opcode class but near, and every error.
    tbl = '{
      '{CMD_TICK, 8'hFF, 1, res(0, 0, 0, ST_OK)},     // tick with nothing owed
      '{CMD_NOP,  8'h00, 1, res(0, 0, 0, ST_OK)},     // no operation
      '{CMD_PUSH, 8'h01, 1, res(0, 0, 0, ST_OK)},     // four literals
      '{CMD_PUSH, 8'hFF, 1, res(1, 8'hFF, 0, ST_OK)},
      '{CMD_PUSH, 8'h00, 1, res(1, 8'h00, 0, ST_OK)},
      '{CMD_PUSH, 8'hA5, 1, res(1, 8'hA5, 0, ST_OK)},
      '{CMD_PUSH, 8'h5A, 1, res(1, 8'h5A, 0, ST_OK)},
      '{CMD_PUSH, 8'h4C, 0, R0},                      // short match, len 3
      '{CMD_PUSH, 8'h00, 0, R0},
      '{CMD_PUSH, 8'h77, 1, res(0, 0, 1, ST_BUSY)},   // push while copying
      '{CMD_TICK, 8'h00, 0, R0},
      '{CMD_TICK, 8'h00, 0, R0},
      '{CMD_TICK, 8'h00, 0, R0},
      '{CMD_PUSH, 8'h24, 0, R0},                      // mid match, len 6
      '{CMD_PUSH, 8'h00, 0, R0},
      '{CMD_PUSH, 8'h00, 0, R0},
      '{CMD_TICK, 8'h00, 0, R0}, '{CMD_TICK, 8'h00, 0, R0},
      '{CMD_TICK, 8'h00, 0, R0}, '{CMD_TICK, 8'h00, 0, R0},
      '{CMD_TICK, 8'h00, 0, R0}, '{CMD_TICK, 8'h00, 0, R0},
      '{CMD_PUSH, 8'h10, 0, R0},                      // far opcode: offset too far
      '{CMD_PUSH, 8'h05, 0, R0},
      '{CMD_PUSH, 8'h00, 0, R0},
      '{CMD_PUSH, 8'h00, 1, res(0, 0, 0, ST_BADOFF)},
      '{CMD_PAGE, 8'h00, 1, res(0, 0, 0, ST_OK)},
      '{CMD_PUSH, 8'h20, 1, res(0, 0, 0, ST_OK)},     // opcode at lead
      '{CMD_PAGE, 8'h00, 1, res(0, 0, 0, ST_OK)},
      '{CMD_PUSH, 8'h11, 1, res(0, 0, 0, ST_END)},    // end marker
      '{CMD_PUSH, 8'h42, 1, res(0, 0, 0, ST_AFTER)},  // push after end
      '{CMD_PAGE, 8'h00, 1, res(0, 0, 0, ST_OK)},
      '{CMD_PUSH, 8'h00, 0, R0},                      // lead extension
      '{CMD_PUSH, 8'h01, 0, R0},
      '{CMD_PAGE, 8'h00, 1, res(0, 0, 0, ST_OK)},
      '{CMD_PUSH, 8'h02, 0, R0},
      '{CMD_PUSH, 8'h11, 0, R0}, '{CMD_PUSH, 8'h22, 0, R0},
      '{CMD_PUSH, 8'h33, 0, R0}, '{CMD_PUSH, 8'h44, 0, R0},
      '{CMD_PUSH, 8'h55, 0, R0},
      '{CMD_PUSH, 8'h0F, 1, res(0, 0, 0, ST_BADOP)}   // bad opcode
    };
    foreach (tbl[i]) send(tbl[i].cmd, tbl[i].byt, tbl[i].known, tbl[i].res);

    drain();  // sender holds off until every result has come back

    count = 0;
    while (count < 2000) random_page(count);

    s_axis_tvalid <= 1'b0;
    done_in = 1'b1;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d results, %0d pages, %0d copied match bytes",
             n_out, n_pages, n_copied);
    if (errors == 0 && expected_q.size() == 0)
      $display("** lz77_page_decompressor: PASSED **");
    else
      $display("** lz77_page_decompressor: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
design/lz77pd_pkg.sv
design/lz77_page_decompressor.sv
test/tb_lz77_page_decompressor.sv
